### rtl/core/hci_pkg.sv
// Shared types and constants for the vec4 cubic Hermite interpolator.
package hci_pkg;

  // Default component width (signed Q8.8)
  localparam int COMP_W_DEF = 16;

  // Width of one result component field
  localparam int OUT_W = 16;

  // Blend position of 1.0 in unsigned Q1.15
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Weight of 1.0 in Q2.30
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // Number of vectors and components per item
  localparam int NUM_VEC  = 4;
  localparam int NUM_COMP = 4;

  // Input item: four packed vec4 operands and the blend position
  typedef struct packed {
    logic [63:0] start_point;
    logic [63:0] start_tangent;
    logic [63:0] end_point;
    logic [63:0] end_tangent;
    logic [15:0] blend_pos;
  } hci_in_t;

  // Result item: four saturated components and the clip flag
  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic signed [OUT_W-1:0] out_w;
    logic                    saturated;
  } hci_out_t;

endpackage

### rtl/core/hci_in_if.sv
// Valid/ready channel carrying one input item of the interpolator.
interface hci_in_if;
  import hci_pkg::*;

  logic    valid;
  logic    ready;
  hci_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/hci_out_if.sv
// Valid/ready channel carrying one result item of the interpolator.
interface hci_out_if;
  import hci_pkg::*;

  logic     valid;
  logic     ready;
  hci_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/vec4_cubic_hermite_interp.sv
// Pipelined vec4 cubic Hermite interpolator with saturating Q8.8 results.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------
//   in_if    | sink      | valid/ready         | P0, T0, P1, T1, blend_pos
//   out_if   | source    | valid/ready         | out_x..out_w, saturated
//
// One item per cycle while out_if is ready; an accepted item passes through
// the six register stages (square, cube, weights, products, sum and round,
// clamp) before it is presented on out_if.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled output holds its item; each stage advances when it is empty or
// the stage after it advances, so bubbles close up and nothing is lost.
module vec4_cubic_hermite_interp #(
  parameter int COMPONENT_WIDTH = hci_pkg::COMP_W_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  hci_in_if.sink   in_if,
  hci_out_if.source out_if
);
  import hci_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int PW    = CW + 32;          // product width
  localparam int SUMW  = CW + 34;          // four-term sum width
  localparam int RW    = SUMW - 30;        // rounded result width
  localparam int SATW  = (CW < OUT_W) ? CW : OUT_W;
  localparam int NSTG  = 6;

  localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(64'sd536870912);
  localparam logic signed [RW-1:0]   SAT_HI   = RW'((64'sd1 <<< (SATW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0]   SAT_LO   = RW'(-(64'sd1 <<< (SATW - 1)));
  localparam logic signed [OUT_W-1:0] OUT_HI  = OUT_W'(SAT_HI);
  localparam logic signed [OUT_W-1:0] OUT_LO  = OUT_W'(SAT_LO);

  // Stage control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  // Stage 1: clamped blend, square, unpacked components
  logic        [15:0]   s1_a_r,   s1_a_nxt;
  logic        [30:0]   s1_a2_r,  s1_a2_nxt;
  logic signed [CW-1:0] s1_cmp_r  [NUM_VEC][NUM_COMP];
  logic signed [CW-1:0] s1_cmp_nxt[NUM_VEC][NUM_COMP];

  // Stage 2: cube
  logic        [15:0]   s2_a_r;
  logic        [30:0]   s2_a2_r;
  logic        [45:0]   s2_a3_r,  s2_a3_nxt;
  logic signed [CW-1:0] s2_cmp_r  [NUM_VEC][NUM_COMP];

  // Stage 3: weights in Q2.30, ordered P0, T0, P1, T1
  logic signed [31:0]   s3_w_r    [NUM_VEC];
  logic signed [31:0]   s3_w_nxt  [NUM_VEC];
  logic signed [CW-1:0] s3_cmp_r  [NUM_VEC][NUM_COMP];

  // Stage 4: products
  logic signed [PW-1:0] s4_prd_r  [NUM_VEC][NUM_COMP];
  logic signed [PW-1:0] s4_prd_nxt[NUM_VEC][NUM_COMP];

  // Stage 5: rounded sums
  logic signed [RW-1:0] s5_rnd_r  [NUM_COMP];
  logic signed [RW-1:0] s5_rnd_nxt[NUM_COMP];

  // Stage 6: output register
  logic signed [OUT_W-1:0] s6_res_r  [NUM_COMP];
  logic signed [OUT_W-1:0] s6_res_nxt[NUM_COMP];
  logic                    s6_sat_r, s6_sat_nxt;

  logic [127:0] pk_ext [NUM_VEC];
  logic [31:0]  a_sq;
  logic [46:0]  a_cube;
  logic signed [47:0] a_x, a2_x, a3_x, t01, t10, t11;
  logic signed [31:0] w01;
  logic signed [SUMW-1:0] sum [NUM_COMP];
  logic [NUM_COMP-1:0] clip;

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_if.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  // Move valid bits along with the data
  always_comb begin
    vld_nxt[0] = adv[0] ? in_if.valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_if.ready = adv[0];

  // Stage 1: clamp blend, square it, unpack components
  always_comb begin
    s1_a_nxt  = (in_if.payload.blend_pos > ONE_Q15) ? ONE_Q15 : in_if.payload.blend_pos;
    a_sq      = s1_a_nxt * s1_a_nxt;
    s1_a2_nxt = a_sq[30:0];
    pk_ext[0] = {64'd0, in_if.payload.start_point};
    pk_ext[1] = {64'd0, in_if.payload.start_tangent};
    pk_ext[2] = {64'd0, in_if.payload.end_point};
    pk_ext[3] = {64'd0, in_if.payload.end_tangent};
    for (int v = 0; v < NUM_VEC; v++) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        s1_cmp_nxt[v][k] = signed'(pk_ext[v][k*CW +: CW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_a_r   <= s1_a_nxt;
      s1_a2_r  <= s1_a2_nxt;
      s1_cmp_r <= s1_cmp_nxt;
    end
  end

  // Stage 2: cube
  always_comb begin
    a_cube    = s1_a2_r * s1_a_r;
    s2_a3_nxt = a_cube[45:0];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_a_r   <= s1_a_r;
      s2_a2_r  <= s1_a2_r;
      s2_a3_r  <= s2_a3_nxt;
      s2_cmp_r <= s1_cmp_r;
    end
  end

  // Stage 3: basis weights at scale 2^45, rounded to Q2.30
  always_comb begin
    a_x  = signed'({32'd0, s2_a_r});
    a2_x = signed'({17'd0, s2_a2_r});
    a3_x = signed'({2'd0, s2_a3_r});
    t01  = (a2_x <<< 16) + (a2_x <<< 15) - (a3_x <<< 1) + 48'sd16384;
    t10  = a3_x - (a2_x <<< 16) + (a_x <<< 30) + 48'sd16384;
    t11  = a3_x - (a2_x <<< 15) + 48'sd16384;
    w01  = signed'(t01[46:15]);
    // h00 is the complement of h01 so the point weights sum to one
    s3_w_nxt[0] = ONE_Q30 - w01;
    s3_w_nxt[1] = signed'(t10[46:15]);
    s3_w_nxt[2] = w01;
    s3_w_nxt[3] = signed'(t11[46:15]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_w_r   <= s3_w_nxt;
      s3_cmp_r <= s2_cmp_r;
    end
  end

  // Stage 4: weight every component
  always_comb begin
    for (int v = 0; v < NUM_VEC; v++) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        s4_prd_nxt[v][k] = PW'(s3_cmp_r[v][k]) * PW'(s3_w_r[v]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_prd_r <= s4_prd_nxt;
    end
  end

  // Stage 5: sum the four terms, round half up to Q8.8
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      sum[k] = SUMW'(s4_prd_r[0][k]) + SUMW'(s4_prd_r[1][k])
             + SUMW'(s4_prd_r[2][k]) + SUMW'(s4_prd_r[3][k]) + RND_HALF;
      s5_rnd_nxt[k] = signed'(sum[k][SUMW-1:30]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_rnd_r <= s5_rnd_nxt;
    end
  end

  // Stage 6: clamp to the component range and flag any clip
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      if (s5_rnd_r[k] > SAT_HI) begin
        s6_res_nxt[k] = OUT_HI;
        clip[k]       = 1'b1;
      end else if (s5_rnd_r[k] < SAT_LO) begin
        s6_res_nxt[k] = OUT_LO;
        clip[k]       = 1'b1;
      end else begin
        s6_res_nxt[k] = OUT_W'(s5_rnd_r[k]);
        clip[k]       = 1'b0;
      end
    end
    s6_sat_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_res_r <= s6_res_nxt;
      s6_sat_r <= s6_sat_nxt;
    end
  end

  // Drive the result channel
  assign out_if.valid             = vld_r[NSTG-1];
  assign out_if.payload.out_x     = s6_res_r[0];
  assign out_if.payload.out_y     = s6_res_r[1];
  assign out_if.payload.out_z     = s6_res_r[2];
  assign out_if.payload.out_w     = s6_res_r[3];
  assign out_if.payload.saturated = s6_sat_r;

`ifndef SYNTHESIS
  // Input may only be taken while some stage has room or the output drains
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> (!(&vld_r) || out_if.ready))
    else $error("input accepted with a full, stalled pipeline");

  // An item leaving the sum and round stage reaches the output register
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && adv[NSTG-1]) |=> vld_r[NSTG-1])
    else $error("item lost between last two stages");

  // Point weights sum to one, tangent weights keep their signs
  a_weights: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> ((s3_w_r[0] + s3_w_r[2]) == ONE_Q30)
                 && (s3_w_r[1] >= 0) && (s3_w_r[3] <= 0))
    else $error("basis weights out of range");

  // A clip flag means some component sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.payload.saturated) |->
      ((s6_res_r[0] == OUT_HI) || (s6_res_r[0] == OUT_LO) ||
       (s6_res_r[1] == OUT_HI) || (s6_res_r[1] == OUT_LO) ||
       (s6_res_r[2] == OUT_HI) || (s6_res_r[2] == OUT_LO) ||
       (s6_res_r[3] == OUT_HI) || (s6_res_r[3] == OUT_LO)))
    else $error("saturated flag without a clipped component");
`endif

endmodule

### tb/tb_vec4_cubic_hermite_interp.sv
// Self-checking testbench for the vec4 cubic Hermite interpolator.
module tb_vec4_cubic_hermite_interp;
  import hci_pkg::*;

  localparam int COMP_W      = COMP_W_DEF;
  localparam int RANDOM_ITEMS = 735;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_HOLD_OFF
  } rdy_mode_e;

  logic clk;
  logic rst_n;

  hci_in_if  in_ch();
  hci_out_if out_ch();

  vec4_cubic_hermite_interp #(
    .COMPONENT_WIDTH(COMP_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  hci_in_t  pending_items[$];
  hci_out_t interp_expected[$];
  int       mismatch_count = 0;

  // Sender burst state
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall state
  rdy_mode_e rdy_mode  = RDY_ALWAYS;
  int        mode_left = 0;
  int        cyc_count = 0;

  // Free-running clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Read component k of a packed vector, sign-extended from COMP_W bits
  function automatic longint comp_at(logic [63:0] vec, int k);
    logic [63:0] raw;
    int          pos;
    pos = k * COMP_W;
    if (pos >= 64) return 0;
    raw = (vec >> pos) & ((64'd1 << COMP_W) - 64'd1);
    if (raw[COMP_W-1]) return longint'(raw) - (longint'(1) << COMP_W);
    return longint'(raw);
  endfunction

  // Interpolate one item: Q2.30 weights, exact sum, round to Q8.8, clip
  function automatic hci_out_t hermite_blend(hci_in_t it);
    longint   a, a2, a3;
    longint   wp0, wp1, wt0, wt1;
    longint   acc, r, hi, lo;
    int       sat_w;
    logic     clipped;
    logic [OUT_W-1:0] res [NUM_COMP];
    hci_out_t o;
    a = longint'(it.blend_pos);
    if (a > longint'(ONE_Q15)) a = longint'(ONE_Q15);
    a2 = a * a;
    a3 = a2 * a;
    wp1 = (3 * a2 * 32768 - 2 * a3 + 16384) >>> 15;
    wp0 = (longint'(1) << 30) - wp1;
    wt0 = (a3 - 2 * a2 * 32768 + a * (longint'(1) << 30) + 16384) >>> 15;
    wt1 = (a3 - a2 * 32768 + 16384) >>> 15;
    sat_w = (COMP_W < OUT_W) ? COMP_W : OUT_W;
    hi = (longint'(1) << (sat_w - 1)) - 1;
    lo = -(longint'(1) << (sat_w - 1));
    clipped = 1'b0;
    for (int k = 0; k < NUM_COMP; k++) begin
      acc = comp_at(it.start_point, k) * wp0 + comp_at(it.end_point, k) * wp1
          + comp_at(it.start_tangent, k) * wt0 + comp_at(it.end_tangent, k) * wt1;
      r = (acc + (longint'(1) << 29)) >>> 30;
      if (r > hi) begin
        r = hi;
        clipped = 1'b1;
      end else if (r < lo) begin
        r = lo;
        clipped = 1'b1;
      end
      res[k] = r[OUT_W-1:0];
    end
    o.out_x     = res[0];
    o.out_y     = res[1];
    o.out_z     = res[2];
    o.out_w     = res[3];
    o.saturated = clipped;
    return o;
  endfunction

  function automatic logic [63:0] pack4(logic [15:0] x, logic [15:0] y,
                                        logic [15:0] z, logic [15:0] w);
    return {w, z, y, x};
  endfunction

  // Component value biased towards extremes and small magnitudes
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_vec();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return pack4(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endfunction

  function automatic logic [15:0] rand_blend();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return ONE_Q15;
      2:       return 16'($urandom_range(0, 65535));
      3:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic queue_item(logic [63:0] p0, logic [63:0] t0, logic [63:0] p1,
                            logic [63:0] t1, logic [15:0] blend);
    hci_in_t it;
    it.start_point   = p0;
    it.start_tangent = t0;
    it.end_point     = p1;
    it.end_tangent   = t1;
    it.blend_pos     = blend;
    pending_items.push_back(it);
  endtask

  task automatic check_field(string fname, logic [OUT_W-1:0] exp_v,
                             logic [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d",
               $time, fname, $signed(exp_v), $signed(act_v));
    end
  endtask

  // Drive input items in bursts separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= pending_items.pop_front();
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side on a changing pattern
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (mode_left == 0) begin
      rdy_mode  <= rdy_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(5, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rdy_mode)
      RDY_ALWAYS:   out_ch.ready <= 1'b1;
      RDY_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:   out_ch.ready <= (cyc_count % 4 == 0);
      RDY_HOLD_OFF: out_ch.ready <= (mode_left > 40);
      default:      out_ch.ready <= 1'b1;
    endcase
  end

  // Record accepted items and check each accepted result against the oldest expectation
  always @(posedge clk) begin
    hci_out_t want;
    hci_out_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        interp_expected.push_back(hermite_blend(in_ch.payload));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (interp_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none actual %h", $time, got);
        end else begin
          want = interp_expected.pop_front();
          check_field("out_x", want.out_x, got.out_x);
          check_field("out_y", want.out_y, got.out_y);
          check_field("out_z", want.out_z, got.out_z);
          check_field("out_w", want.out_w, got.out_w);
          check_field("saturated", {15'd0, want.saturated}, {15'd0, got.saturated});
        end
      end
    end
  end

  // Reset, fill the item queue, then wait for the results to drain
  initial begin
    logic [63:0] mix_a;
    logic [63:0] mix_b;
    rst_n          = 1'b0;

    mix_a = pack4(16'h0100, 16'hFF00, 16'h7FFF, 16'h8000);
    mix_b = pack4(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);

    // Endpoints and clamping of the blend position
    queue_item('0, '0, '0, '0, 16'd0);
    queue_item(mix_a, mix_b, mix_b, mix_a, 16'd0);
    queue_item(mix_a, mix_b, mix_b, mix_a, ONE_Q15);
    queue_item(mix_a, mix_b, mix_b, mix_a, 16'd32769);
    queue_item(mix_a, mix_b, mix_b, mix_a, 16'hFFFF);
    queue_item(mix_a, mix_b, mix_b, mix_a, 16'd1);
    queue_item(mix_a, mix_b, mix_b, mix_a, 16'd32767);
    queue_item(mix_a, mix_b, mix_b, mix_a, 16'd16384);
    // Clip high and low on every component
    queue_item({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h8000}}, 16'd16384);
    queue_item({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h7FFF}}, 16'd16384);
    // Clip on one component only
    queue_item(pack4(16'h7FFF, 16'd0, 16'd0, 16'd0), pack4(16'h7FFF, 16'd5, 16'd0, 16'd0),
               pack4(16'h7FFF, 16'd0, 16'd9, 16'd0), pack4(16'h8000, 16'd0, 16'd0, 16'd3),
               16'd12000);
    // All bits set, tangents alone, odd positions
    queue_item('1, '1, '1, '1, 16'h7FFF);
    queue_item('1, '1, '1, '1, 16'hFFFF);
    queue_item('0, {4{16'h7FFF}}, '0, {4{16'h7FFF}}, 16'd8192);
    queue_item('0, {4{16'h8000}}, '0, {4{16'h7FFF}}, 16'd24576);
    queue_item(pack4(16'h0001, 16'hFFFF, 16'h0080, 16'hFF80), '0,
               pack4(16'hFFFF, 16'h0001, 16'hFF80, 16'h0080), '0, 16'd16384);
    queue_item({4{16'h5555}}, {4{16'hAAAA}}, {4{16'hAAAA}}, {4{16'h5555}}, 16'h5555);

    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_item(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_blend());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_ch.valid) @(posedge clk);
    while (interp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_vec4_cubic_hermite_interp passed");
    end else begin
      $display("tb_vec4_cubic_hermite_interp failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("tb_vec4_cubic_hermite_interp failed");
    $finish;
  end

endmodule
